// ----- hw/rtl/dip_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Decimal integer parser package
// Shared widths, character codes, register map and the record that carries a
// finished parse from the accumulator to the output formatter.
// ----------------------------------------------------------------------------
package dip_pkg;

  // Widths of the stream payloads and of the configuration port.
  localparam int unsigned CharW  = 8;
  localparam int unsigned ValueW = 64;
  localparam int unsigned DataW  = 32;
  localparam int unsigned AddrW  = 2;

  // ASCII codes that the parser recognises.
  localparam logic [CharW-1:0] CharZero  = 8'h30;
  localparam logic [CharW-1:0] CharNine  = 8'h39;
  localparam logic [CharW-1:0] CharPlus  = 8'h2B;
  localparam logic [CharW-1:0] CharMinus = 8'h2D;

  // Register map: the only register is the mode bit at byte address zero.
  localparam logic [AddrW-1:0] AddrSignedMode = 2'd0;
  localparam logic SignedModeReset = 1'b1;

  // A parse that has seen its last character, as handed to the formatter.
  typedef struct packed {
    logic [ValueW-1:0] magnitude;
    logic              is_negative;
    logic              digit_seen;
    logic              has_failed;
  } parse_t;

endpackage : dip_pkg
`default_nettype wire

// ----- hw/rtl/decimal_integer_parser.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Decimal integer parser
// Turns a stream of ASCII decimal characters into a 64-bit integer.
// ----------------------------------------------------------------------------
// Usage:
//   The slave stream carries one character per transfer in tdata, with tlast
//   marking the final character of a number. Non-final characters produce no
//   output; the final one produces one master-stream transfer holding the
//   value (two's complement in signed mode, zero on failure) in tdata and the
//   ok flag in tuser. The APB port holds the signed-mode bit at address 0;
//   write it only while no number is in flight.
//   Throughput is one character per cycle while the slave side is not stalled.
//   The path is three registers deep: input register, accumulator (one
//   multiply-by-ten and add per character), then the output register.
//   Reset clears all stages and the parse state and sets signed mode. When
//   the receiver stalls, the output register holds its result while the
//   finished-parse and input registers keep accepting; digits that are not
//   final keep flowing into the accumulator, and the slave side stalls only
//   once a further final character finds both later stages full.
// ----------------------------------------------------------------------------
module decimal_integer_parser (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  // Slave stream; tdata: [7:0] char_code.
  input  wire logic                       s_axis_tvalid_i,
  output logic                            s_axis_tready_o,
  input  wire logic [dip_pkg::CharW-1:0]  s_axis_tdata_i,
  input  wire logic                       s_axis_tlast_i,
  // Master stream; tdata: [63:0] value_bits; tuser: [0] ok.
  output logic                            m_axis_tvalid_o,
  input  wire logic                       m_axis_tready_i,
  output logic      [dip_pkg::ValueW-1:0] m_axis_tdata_o,
  output logic                            m_axis_tuser_o,
  // Configuration port.
  input  wire logic                       psel_i,
  input  wire logic                       penable_i,
  input  wire logic                       pwrite_i,
  input  wire logic [dip_pkg::AddrW-1:0]  paddr_i,
  input  wire logic [dip_pkg::DataW-1:0]  pwdata_i,
  output logic      [dip_pkg::DataW-1:0]  prdata_o,
  output logic                            pready_o
);

  logic            signed_mode;
  logic            fin_valid;
  logic            fin_ready;
  dip_pkg::parse_t fin_parse;

  dip_cfg u_cfg (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel_i        (psel_i),
    .penable_i     (penable_i),
    .pwrite_i      (pwrite_i),
    .paddr_i       (paddr_i),
    .pwdata_i      (pwdata_i),
    .prdata_o      (prdata_o),
    .pready_o      (pready_o),
    .signed_mode_o (signed_mode)
  );

  dip_accum u_accum (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .signed_mode_i (signed_mode),
    .in_valid_i    (s_axis_tvalid_i),
    .in_ready_o    (s_axis_tready_o),
    .in_char_i     (s_axis_tdata_i),
    .in_last_i     (s_axis_tlast_i),
    .fin_valid_o   (fin_valid),
    .fin_ready_i   (fin_ready),
    .fin_parse_o   (fin_parse)
  );

  dip_format u_format (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .signed_mode_i (signed_mode),
    .fin_valid_i   (fin_valid),
    .fin_ready_o   (fin_ready),
    .fin_parse_i   (fin_parse),
    .out_valid_o   (m_axis_tvalid_o),
    .out_ready_i   (m_axis_tready_i),
    .out_value_o   (m_axis_tdata_o),
    .out_ok_o      (m_axis_tuser_o)
  );

endmodule : decimal_integer_parser
`default_nettype wire

// ----- hw/rtl/dip_cfg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Decimal integer parser configuration registers
// APB-style register file holding the signed-mode bit.
// ----------------------------------------------------------------------------
module dip_cfg (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      psel_i,
  input  wire logic                      penable_i,
  input  wire logic                      pwrite_i,
  input  wire logic [dip_pkg::AddrW-1:0] paddr_i,
  input  wire logic [dip_pkg::DataW-1:0] pwdata_i,
  output logic      [dip_pkg::DataW-1:0] prdata_o,
  output logic                           pready_o,
  output logic                           signed_mode_o
);

  logic signed_mode_q;
  logic signed_mode_d;
  logic wr_en;

  // Every access completes without wait states; pready is tied high.
  assign pready_o = 1'b1;
  assign wr_en    = psel_i && penable_i && pwrite_i && (paddr_i == dip_pkg::AddrSignedMode);

  always_comb begin
    signed_mode_d = signed_mode_q;
    if (wr_en) begin
      signed_mode_d = pwdata_i[0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      signed_mode_q <= dip_pkg::SignedModeReset;
    end else begin
      signed_mode_q <= signed_mode_d;
    end
  end

  // Read back; unmapped addresses read as zero.
  always_comb begin
    prdata_o = '0;
    if (paddr_i == dip_pkg::AddrSignedMode) begin
      prdata_o = {{(dip_pkg::DataW-1){1'b0}}, signed_mode_q};
    end
  end

  assign signed_mode_o = signed_mode_q;

endmodule : dip_cfg
`default_nettype wire

// ----- hw/rtl/dip_accum.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Decimal integer parser accumulator
// Registers each incoming character, folds it into the running parse state and
// hands the finished parse to the formatter on the last character.
// ----------------------------------------------------------------------------
module dip_accum (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      signed_mode_i,
  input  wire logic                      in_valid_i,
  output logic                           in_ready_o,
  input  wire logic [dip_pkg::CharW-1:0] in_char_i,
  input  wire logic                      in_last_i,
  output logic                           fin_valid_o,
  input  wire logic                      fin_ready_i,
  output dip_pkg::parse_t                fin_parse_o
);

  localparam int unsigned ProdW = dip_pkg::ValueW + 4;

  // Input register.
  logic                      in_valid_q;
  logic [dip_pkg::CharW-1:0] in_char_q;
  logic                      in_last_q;

  // Running parse state.
  logic [dip_pkg::ValueW-1:0] mag_q, mag_d;
  logic neg_q, neg_d;
  logic start_q, start_d;
  logic seen_q, seen_d;
  logic failed_q, failed_d;

  // Finished parse register.
  logic            fin_valid_q, fin_valid_d;
  dip_pkg::parse_t fin_parse_q;

  logic fin_free;
  logic step;
  logic is_sign;
  logic char_is_num;
  logic [ProdW-1:0] prod;
  logic [ProdW-1:0] digit_ext;
  dip_pkg::parse_t next_parse;

  // A character is consumed unless it is the last one and the finished
  // parse register is still occupied.
  assign fin_free   = !fin_valid_q || fin_ready_i;
  assign step       = in_valid_q && (!in_last_q || fin_free);
  assign in_ready_o = !in_valid_q || step;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_char_q <= in_char_i;
      in_last_q <= in_last_i;
    end
  end

  // Classify the character and form magnitude * 10 + digit as (m << 3) + (m << 1) + d.
  assign is_sign     = (in_char_q == dip_pkg::CharPlus) || (in_char_q == dip_pkg::CharMinus);
  assign char_is_num = (in_char_q >= dip_pkg::CharZero) && (in_char_q <= dip_pkg::CharNine);
  assign digit_ext   = {{(ProdW-dip_pkg::CharW){1'b0}}, in_char_q - dip_pkg::CharZero};
  assign prod        = {1'b0, mag_q, 3'b000} + {3'b000, mag_q, 1'b0} + digit_ext;

  // Fold the character into the parse state.
  always_comb begin
    next_parse.magnitude   = mag_q;
    next_parse.is_negative = neg_q;
    next_parse.digit_seen  = seen_q;
    next_parse.has_failed  = failed_q;
    if (!failed_q) begin
      if (start_q && signed_mode_i && is_sign) begin
        next_parse.is_negative = (in_char_q == dip_pkg::CharMinus);
      end else if (!char_is_num) begin
        next_parse.has_failed = 1'b1;
      end else if (prod[ProdW-1:dip_pkg::ValueW] != '0) begin
        // The product would pass the largest 64-bit value.
        next_parse.has_failed = 1'b1;
      end else begin
        next_parse.magnitude  = prod[dip_pkg::ValueW-1:0];
        next_parse.digit_seen = 1'b1;
      end
    end
  end

  // State update; the last character returns the state to its idle values.
  always_comb begin
    mag_d    = mag_q;
    neg_d    = neg_q;
    start_d  = start_q;
    seen_d   = seen_q;
    failed_d = failed_q;
    if (step) begin
      if (in_last_q) begin
        mag_d    = '0;
        neg_d    = 1'b0;
        start_d  = 1'b1;
        seen_d   = 1'b0;
        failed_d = 1'b0;
      end else begin
        mag_d    = next_parse.magnitude;
        neg_d    = next_parse.is_negative;
        start_d  = 1'b0;
        seen_d   = next_parse.digit_seen;
        failed_d = next_parse.has_failed;
      end
    end
  end

  always_comb begin
    fin_valid_d = fin_valid_q && !fin_ready_i;
    if (step && in_last_q) begin
      fin_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mag_q       <= '0;
      neg_q       <= 1'b0;
      start_q     <= 1'b1;
      seen_q      <= 1'b0;
      failed_q    <= 1'b0;
      fin_valid_q <= 1'b0;
    end else begin
      mag_q       <= mag_d;
      neg_q       <= neg_d;
      start_q     <= start_d;
      seen_q      <= seen_d;
      failed_q    <= failed_d;
      fin_valid_q <= fin_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step && in_last_q) begin
      fin_parse_q <= next_parse;
    end
  end

  assign fin_valid_o = fin_valid_q;
  assign fin_parse_o = fin_parse_q;

`ifndef SYNTHESIS
  // Between strings the parse state is fully cleared.
  a_start_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_q |-> (mag_q == '0) && !neg_q && !seen_q && !failed_q)
    else $error("dip_accum: parse state not clear at string start");

  // No digit accepted means the magnitude is still zero.
  a_mag_needs_digit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !seen_q |-> (mag_q == '0))
    else $error("dip_accum: magnitude nonzero without a digit");

  // A finished parse only appears after a last character was consumed.
  a_fin_from_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(fin_valid_q) |-> $past(step && in_last_q))
    else $error("dip_accum: finished parse without a last character");
`endif

endmodule : dip_accum
`default_nettype wire

// ----- hw/rtl/dip_format.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Decimal integer parser output formatter
// Range-checks a finished parse, applies the sign and holds the result in the
// output register until the receiver takes it.
// ----------------------------------------------------------------------------
module dip_format (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       signed_mode_i,
  input  wire logic                       fin_valid_i,
  output logic                            fin_ready_o,
  input  wire dip_pkg::parse_t            fin_parse_i,
  output logic                            out_valid_o,
  input  wire logic                       out_ready_i,
  output logic      [dip_pkg::ValueW-1:0] out_value_o,
  output logic                            out_ok_o
);

  logic                       out_valid_q;
  logic [dip_pkg::ValueW-1:0] out_value_q, value_d;
  logic                       out_ok_q, ok_d;
  logic                       out_free;
  logic                       lower_zero;

  assign out_free    = !out_valid_q || out_ready_i;
  assign fin_ready_o = out_free;
  assign lower_zero  = (fin_parse_i.magnitude[dip_pkg::ValueW-2:0] == '0);

  // Range check and two's-complement conversion.
  always_comb begin
    ok_d    = !fin_parse_i.has_failed && fin_parse_i.digit_seen;
    value_d = fin_parse_i.magnitude;
    if (signed_mode_i) begin
      if (fin_parse_i.is_negative) begin
        // Magnitudes up to 2^63 fit, the minimum value included.
        if (fin_parse_i.magnitude[dip_pkg::ValueW-1] && !lower_zero) begin
          ok_d = 1'b0;
        end
        value_d = (~fin_parse_i.magnitude) + {{(dip_pkg::ValueW-1){1'b0}}, 1'b1};
      end else if (fin_parse_i.magnitude[dip_pkg::ValueW-1]) begin
        ok_d = 1'b0;
      end
    end else if (fin_parse_i.is_negative) begin
      ok_d = 1'b0;
    end
    if (!ok_d) begin
      value_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= fin_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free && fin_valid_i) begin
      out_value_q <= value_d;
      out_ok_q    <= ok_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_value_o = out_value_q;
  assign out_ok_o    = out_ok_q;

`ifndef SYNTHESIS
  // A failed parse always reports a zero value.
  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_ok_q |-> (out_value_q == '0))
    else $error("dip_format: failed result with nonzero value");

  // A finished parse is taken whenever the output register has room.
  a_take_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fin_valid_i && out_free |=> out_valid_q)
    else $error("dip_format: finished parse not moved to output");

  // A stalled result stays on offer unchanged.
  a_hold_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_ready_i |=> out_valid_q && $stable(out_value_q) && $stable(out_ok_q))
    else $error("dip_format: stalled result changed");
`endif

endmodule : dip_format
`default_nettype wire
